/* src/tun_pkg.sv */
// tun_pkg: field widths and payload structs of the triangle unit normal block.
// No dependencies; imported by triangle_unit_normal_top, tun_checker and the testbench.
`timescale 1ns / 1ps

package tun_pkg;

	localparam int COORD_WIDTH  = 24;
	localparam int NORMAL_WIDTH = 16;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] vertex_a_x;
		logic signed [COORD_WIDTH-1:0] vertex_a_y;
		logic signed [COORD_WIDTH-1:0] vertex_a_z;
		logic signed [COORD_WIDTH-1:0] vertex_b_x;
		logic signed [COORD_WIDTH-1:0] vertex_b_y;
		logic signed [COORD_WIDTH-1:0] vertex_b_z;
		logic signed [COORD_WIDTH-1:0] vertex_c_x;
		logic signed [COORD_WIDTH-1:0] vertex_c_y;
		logic signed [COORD_WIDTH-1:0] vertex_c_z;
	} tun_in_t;

	typedef struct packed {
		logic signed [NORMAL_WIDTH-1:0] normal_x;
		logic signed [NORMAL_WIDTH-1:0] normal_y;
		logic signed [NORMAL_WIDTH-1:0] normal_z;
		logic                           degenerate;
	} tun_out_t;

endpackage

/* src/triangle_unit_normal_top.sv */
// triangle_unit_normal_top: pipelined unit face normal of a triangle.
// Depends on tun_pkg (payload structs, field widths).
//
//   channel   ports                     transfer
//   input     start, busy, triangle     rising edge with start high, busy low
//   output    done, result              every cycle done is high, no backpressure
//
// One triangle per cycle. Stages: edge vectors, products, cross, sign and magnitude,
// maximum, normalize shifts (K = clog2(excess bits of the cross magnitude over 30)),
// squares, sum, 31 root-bit stages of square root, one-bit-per-stage divider, output.
// Reset clears only the valid bits; busy is always low since the output never stalls.
`timescale 1ns / 1ps

module triangle_unit_normal_top
	import tun_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  tun_in_t  triangle,
	output logic     done,
	output tun_out_t result
);

	localparam int CW   = COORD_WIDTH;
	localparam int NW   = NORMAL_WIDTH;
	localparam int PRE  = (CW > 30) ? CW - 30 : 0;
	localparam int DW   = CW + 1;
	localparam int EW   = DW - PRE;
	localparam int PW   = 2 * EW;
	localparam int XW   = PW + 1;
	localparam int MW   = PW;
	localparam int MAGW = (MW > 31) ? MW : 31;
	localparam int EXC  = MAGW - 30;
	localparam int K    = $clog2(EXC);
	localparam int RB   = 31;
	localparam int SW   = 62;
	localparam int DIVW = 33 + NW;

	typedef struct packed {
		logic             deg;
		logic [2:0]       neg;
		logic [2:0][29:0] mag;
	} side_t;

	function automatic logic signed [EW-1:0] trim_edge(input logic signed [DW-1:0] d);
		logic [DW-1:0] m;
		logic [DW-1:0] sh;
		m  = d[DW-1] ? $unsigned(-d) : $unsigned(d);
		sh = m >> PRE;
		return d[DW-1] ? $signed(-sh[EW-1:0]) : $signed(sh[EW-1:0]);
	endfunction

	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	logic signed [CW-1:0] va [3];
	logic signed [CW-1:0] vb [3];
	logic signed [CW-1:0] vc [3];
	assign va[0] = triangle.vertex_a_x;
	assign va[1] = triangle.vertex_a_y;
	assign va[2] = triangle.vertex_a_z;
	assign vb[0] = triangle.vertex_b_x;
	assign vb[1] = triangle.vertex_b_y;
	assign vb[2] = triangle.vertex_b_z;
	assign vc[0] = triangle.vertex_c_x;
	assign vc[1] = triangle.vertex_c_y;
	assign vc[2] = triangle.vertex_c_z;

	logic signed [EW-1:0] u_c [3];
	logic signed [EW-1:0] v_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_c[i] = trim_edge($signed({vb[i][CW-1], vb[i]}) - $signed({va[i][CW-1], va[i]}));
			v_c[i] = trim_edge($signed({vc[i][CW-1], vc[i]}) - $signed({va[i][CW-1], va[i]}));
		end
	end

	// stage 1: edge vectors
	logic                 vld_s1;
	logic signed [EW-1:0] u_s1 [3];
	logic signed [EW-1:0] v_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end
	always_ff @(posedge clk) begin
		u_s1 <= u_c;
		v_s1 <= v_c;
	end

	// stage 2: six partial products of the cross product
	logic                 vld_s2;
	logic signed [PW-1:0] prod_s2 [6];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		prod_s2[0] <= u_s1[1] * v_s1[2];
		prod_s2[1] <= u_s1[2] * v_s1[1];
		prod_s2[2] <= u_s1[2] * v_s1[0];
		prod_s2[3] <= u_s1[0] * v_s1[2];
		prod_s2[4] <= u_s1[0] * v_s1[1];
		prod_s2[5] <= u_s1[1] * v_s1[0];
	end

	// stage 3: cross components
	logic                 vld_s3;
	logic signed [XW-1:0] cross_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cross_s3[i] <= $signed({prod_s2[2*i][PW-1], prod_s2[2*i]})
				- $signed({prod_s2[2*i+1][PW-1], prod_s2[2*i+1]});
		end
	end

	// stage 4: sign and magnitude, zero test
	logic                 vld_s4;
	logic                 deg_s4;
	logic [2:0]           neg_s4;
	logic [MAGW-1:0]      mag_s4 [3];
	logic signed [XW-1:0] abs_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_c[i] = cross_s3[i][XW-1] ? -cross_s3[i] : cross_s3[i];
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end
	always_ff @(posedge clk) begin
		deg_s4 <= (cross_s3[0] == '0) && (cross_s3[1] == '0) && (cross_s3[2] == '0);
		for (int i = 0; i < 3; i++) begin
			neg_s4[i] <= cross_s3[i][XW-1];
			mag_s4[i] <= MAGW'(abs_c[i][MW-1:0]);
		end
	end

	// stage 5 (normalize index 0): largest magnitude
	logic            nrm_vld_s [K+2];
	logic            nrm_deg_s [K+2];
	logic [2:0]      nrm_neg_s [K+2];
	logic [MAGW-1:0] nrm_max_s [K+2];
	logic [MAGW-1:0] nrm_mag_s [K+2][3];
	logic [MAGW-1:0] max01_c;
	assign max01_c = (mag_s4[0] > mag_s4[1]) ? mag_s4[0] : mag_s4[1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_vld_s[0] <= 1'b0;
		end else begin
			nrm_vld_s[0] <= vld_s4;
		end
	end
	always_ff @(posedge clk) begin
		nrm_deg_s[0] <= deg_s4;
		nrm_neg_s[0] <= neg_s4;
		nrm_max_s[0] <= (max01_c > mag_s4[2]) ? max01_c : mag_s4[2];
		nrm_mag_s[0] <= mag_s4;
	end

	// normalize: halving shift steps bring the largest magnitude below 2^30
	for (genvar gt = 0; gt <= K; gt++) begin : g_norm
		localparam int D = (gt < K) ? (1 << (K - 1 - gt)) : 1;
		logic take;
		if (gt < K) begin : g_step
			assign take = |nrm_max_s[gt][MAGW-1:30+D];
		end else begin : g_last
			assign take = |nrm_max_s[gt][MAGW-1:30];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nrm_vld_s[gt+1] <= 1'b0;
			end else begin
				nrm_vld_s[gt+1] <= nrm_vld_s[gt];
			end
		end
		always_ff @(posedge clk) begin
			nrm_deg_s[gt+1] <= nrm_deg_s[gt];
			nrm_neg_s[gt+1] <= nrm_neg_s[gt];
			nrm_max_s[gt+1] <= take ? (nrm_max_s[gt] >> D) : nrm_max_s[gt];
			for (int i = 0; i < 3; i++) begin
				nrm_mag_s[gt+1][i] <= take ? (nrm_mag_s[gt][i] >> D) : nrm_mag_s[gt][i];
			end
		end
	end

	// squares
	logic        vld_sq;
	side_t       side_sq;
	logic [59:0] sq_sq [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq <= 1'b0;
		end else begin
			vld_sq <= nrm_vld_s[K+1];
		end
	end
	always_ff @(posedge clk) begin
		side_sq.deg <= nrm_deg_s[K+1];
		side_sq.neg <= nrm_neg_s[K+1];
		for (int i = 0; i < 3; i++) begin
			side_sq.mag[i] <= nrm_mag_s[K+1][i][29:0];
			sq_sq[i]       <= nrm_mag_s[K+1][i][29:0] * nrm_mag_s[K+1][i][29:0];
		end
	end

	// square root, one root bit a stage; index 0 holds the sum of squares
	logic          rt_vld_s  [RB+1];
	side_t         rt_side_s [RB+1];
	logic [SW-1:0] rt_rem_s  [RB+1];
	logic [RB-1:0] rt_root_s [RB+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_s[0] <= 1'b0;
		end else begin
			rt_vld_s[0] <= vld_sq;
		end
	end
	always_ff @(posedge clk) begin
		rt_side_s[0] <= side_sq;
		rt_rem_s[0]  <= {2'b00, sq_sq[0]} + {2'b00, sq_sq[1]} + {2'b00, sq_sq[2]};
		rt_root_s[0] <= '0;
	end

	for (genvar gj = 0; gj < RB; gj++) begin : g_sqrt
		localparam int I = RB - 1 - gj;
		logic [63:0] test;
		logic        fit;
		assign test = ({33'd0, rt_root_s[gj]} << (I + 1)) | (64'd1 << (2 * I));
		assign fit  = {2'b00, rt_rem_s[gj]} >= test;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[gj+1] <= 1'b0;
			end else begin
				rt_vld_s[gj+1] <= rt_vld_s[gj];
			end
		end
		always_ff @(posedge clk) begin
			rt_side_s[gj+1] <= rt_side_s[gj];
			rt_rem_s[gj+1]  <= fit ? (rt_rem_s[gj] - test[SW-1:0]) : rt_rem_s[gj];
			rt_root_s[gj+1] <= fit ? (rt_root_s[gj] | (RB'(1) << I)) : rt_root_s[gj];
		end
	end

	// divider, one quotient bit a stage; index 0 holds the rounded numerators
	logic            dv_vld_s  [NW+1];
	logic            dv_deg_s  [NW+1];
	logic [2:0]      dv_neg_s  [NW+1];
	logic [31:0]     dv_den_s  [NW+1];
	logic [DIVW-1:0] dv_rem_s  [NW+1][3];
	logic [NW-1:0]   dv_quo_s  [NW+1][3];
	logic [RB-1:0]   len_c;
	assign len_c = (rt_root_s[RB] == '0) ? RB'(1) : rt_root_s[RB];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= rt_vld_s[RB];
		end
	end
	always_ff @(posedge clk) begin
		dv_deg_s[0] <= rt_side_s[RB].deg;
		dv_neg_s[0] <= rt_side_s[RB].neg;
		dv_den_s[0] <= {len_c, 1'b0};
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= (DIVW'(rt_side_s[RB].mag[i]) << NW) + DIVW'(len_c);
			dv_quo_s[0][i] <= '0;
		end
	end

	for (genvar gd = 0; gd < NW; gd++) begin : g_div
		localparam int B = NW - 1 - gd;
		logic [DIVW-1:0] cmp;
		assign cmp = DIVW'(dv_den_s[gd]) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[gd+1] <= 1'b0;
			end else begin
				dv_vld_s[gd+1] <= dv_vld_s[gd];
			end
		end
		always_ff @(posedge clk) begin
			dv_deg_s[gd+1] <= dv_deg_s[gd];
			dv_neg_s[gd+1] <= dv_neg_s[gd];
			dv_den_s[gd+1] <= dv_den_s[gd];
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[gd][i] >= cmp) begin
					dv_rem_s[gd+1][i] <= dv_rem_s[gd][i] - cmp;
					dv_quo_s[gd+1][i] <= dv_quo_s[gd][i] | (NW'(1) << B);
				end else begin
					dv_rem_s[gd+1][i] <= dv_rem_s[gd][i];
					dv_quo_s[gd+1][i] <= dv_quo_s[gd][i];
				end
			end
		end
	end

	// saturate and apply signs; +1.0 clips, -1.0 is representable
	localparam logic [NW-1:0] SCALE = NW'(1) << (NW - 1);
	logic [NW-1:0] comp_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_deg_s[NW]) begin
				comp_c[i] = '0;
			end else if (dv_neg_s[NW][i]) begin
				comp_c[i] = (dv_quo_s[NW][i] > SCALE) ? SCALE : -dv_quo_s[NW][i];
			end else begin
				comp_c[i] = (dv_quo_s[NW][i] > SCALE - NW'(1)) ? SCALE - NW'(1)
					: dv_quo_s[NW][i];
			end
		end
	end

	logic     done_q;
	tun_out_t result_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld_s[NW];
		end
	end
	always_ff @(posedge clk) begin
		result_q.normal_x   <= $signed(comp_c[0]);
		result_q.normal_y   <= $signed(comp_c[1]);
		result_q.normal_z   <= $signed(comp_c[2]);
		result_q.degenerate <= dv_deg_s[NW];
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* tb/tun_checker.sv */
// tun_checker: predicts the unit normal of each accepted triangle and compares results.
// Depends on tun_pkg; watches the start/busy and done/result channels of the block.
`timescale 1ns / 1ps

module tun_checker
	import tun_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  tun_in_t  triangle,
	input  logic     done,
	input  tun_out_t result,
	output int       fail_count,
	output int       pending
);

	tun_out_t normal_queue[$];

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [NORMAL_WIDTH-1:0] scale_component(logic neg,
			longint unsigned mag, longint unsigned len);
		longint unsigned full, q;
		longint val;
		full = longint'(1) << (NORMAL_WIDTH - 1);
		q = (2 * (mag << (NORMAL_WIDTH - 1)) + len) / (2 * len);
		if (neg) begin
			if (q > full)
				q = full;
			val = -longint'(q);
		end else begin
			if (q > full - 1)
				q = full - 1;
			val = longint'(q);
		end
		return val[NORMAL_WIDTH-1:0];
	endfunction

	function automatic tun_out_t face_normal(tun_in_t t);
		tun_out_t o;
		longint ax, ay, az, ux, uy, uz, vx, vy, vz;
		longint cr[3];
		longint unsigned mag[3], peak, sq_sum, len;
		int sh;
		ax = t.vertex_a_x; ay = t.vertex_a_y; az = t.vertex_a_z;
		ux = longint'(t.vertex_b_x) - ax;
		uy = longint'(t.vertex_b_y) - ay;
		uz = longint'(t.vertex_b_z) - az;
		vx = longint'(t.vertex_c_x) - ax;
		vy = longint'(t.vertex_c_y) - ay;
		vz = longint'(t.vertex_c_z) - az;
		cr[0] = uy * vz - uz * vy;
		cr[1] = uz * vx - ux * vz;
		cr[2] = ux * vy - uy * vx;
		o = '0;
		if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
			o.degenerate = 1'b1;
			return o;
		end
		peak = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
			if (mag[i] > peak)
				peak = mag[i];
		end
		sh = 0;
		while ((peak >> sh) >= (64'd1 << 30))
			sh++;
		sq_sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = mag[i] >> sh;
			sq_sum += mag[i] * mag[i];
		end
		len = root_floor(sq_sum);
		if (len == 0)
			len = 1;
		o.normal_x = scale_component(cr[0] < 0, mag[0], len);
		o.normal_y = scale_component(cr[1] < 0, mag[1], len);
		o.normal_z = scale_component(cr[2] < 0, mag[2], len);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tun_out_t exp_n;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			normal_queue.delete();
		end else begin
			if (done) begin
				if (normal_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					exp_n = normal_queue.pop_front();
					if (result !== exp_n) begin
						$display("%0t: expected %0d %0d %0d %0b actual %0d %0d %0d %0b",
							$time, exp_n.normal_x, exp_n.normal_y, exp_n.normal_z,
							exp_n.degenerate, result.normal_x, result.normal_y,
							result.normal_z, result.degenerate);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				normal_queue = {normal_queue, face_normal(triangle)};
			pending <= normal_queue.size();
		end
	end

endmodule

/* tb/tb_triangle_unit_normal_top.sv */
// tb_triangle_unit_normal_top: drives directed and random triangles into the block.
// Depends on tun_pkg, triangle_unit_normal_top and tun_checker.
`timescale 1ns / 1ps

module tb_triangle_unit_normal_top
	import tun_pkg::*;
();

	localparam int LATENCY   = 62;
	localparam int IDLE_MAX  = 2000;
	localparam int MAX_C     = 8388607;
	localparam int MIN_C     = -8388608;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	tun_in_t  triangle;
	logic     done;
	tun_out_t result;
	int       fail_count;
	int       pending;
	int       idle_cycles;

	triangle_unit_normal_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.triangle(triangle), .done(done), .result(result)
	);

	tun_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.triangle(triangle), .done(done), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [COORD_WIDTH-1:0] rand_coord(int mode);
		case (mode)
			0: return COORD_WIDTH'($urandom_range(0, 1) ? MAX_C : MIN_C);
			1: return COORD_WIDTH'(int'($urandom_range(0, 63)) - 32);
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	// one transfer; start stays high if the next item follows directly
	task automatic send_triangle(tun_in_t t, bit keep);
		triangle <= t;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		if (!keep)
			start <= 1'b0;
	endtask

	function automatic tun_in_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
			int c0, int c1, int c2);
		tun_in_t t;
		t.vertex_a_x = COORD_WIDTH'(a0);
		t.vertex_a_y = COORD_WIDTH'(a1);
		t.vertex_a_z = COORD_WIDTH'(a2);
		t.vertex_b_x = COORD_WIDTH'(b0);
		t.vertex_b_y = COORD_WIDTH'(b1);
		t.vertex_b_z = COORD_WIDTH'(b2);
		t.vertex_c_x = COORD_WIDTH'(c0);
		t.vertex_c_y = COORD_WIDTH'(c1);
		t.vertex_c_z = COORD_WIDTH'(c2);
		return t;
	endfunction

	initial begin
		tun_in_t t;
		tun_in_t dir_list[$];
		int burst, mode;
		start = 1'b0;
		triangle = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// axis-aligned faces give exact +-1.0 (saturation on the positive side)
		dir_list = {dir_list, make_tri(0, 0, 0, 4096, 0, 0, 0, 4096, 0)};
		dir_list = {dir_list, make_tri(0, 0, 0, 0, 4096, 0, 4096, 0, 0)};
		dir_list = {dir_list, make_tri(0, 0, 0, 0, 4096, 0, 0, 0, 4096)};
		dir_list = {dir_list, make_tri(0, 0, 0, 0, 0, 4096, 0, 4096, 0)};
		dir_list = {dir_list, make_tri(0, 0, 0, 0, 0, 4096, 4096, 0, 0)};
		dir_list = {dir_list, make_tri(0, 0, 0, 4096, 0, 0, 0, 0, 4096)};
		// degenerate: all vertices equal, collinear, two vertices equal
		dir_list = {dir_list, make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_list = {dir_list, make_tri(5, 5, 5, 10, 10, 10, 20, 20, 20)};
		dir_list = {dir_list, make_tri(MAX_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, 1, 2, 3)};
		// extreme spans: largest cross product magnitudes
		dir_list = {dir_list, make_tri(MIN_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C,
			MIN_C, MAX_C, MIN_C)};
		dir_list = {dir_list, make_tri(MAX_C, MAX_C, MAX_C, MIN_C, MAX_C, MAX_C,
			MAX_C, MIN_C, MAX_C)};
		dir_list = {dir_list, make_tri(MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MAX_C,
			MAX_C, MAX_C, MIN_C)};
		dir_list = {dir_list, make_tri(MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, MAX_C,
			MIN_C, MIN_C, MIN_C)};
		// tiny triangle: cross magnitude of one
		dir_list = {dir_list, make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0)};
		dir_list = {dir_list, make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1)};
		dir_list = {dir_list, make_tri(-1, -1, -1, 0, -1, -1, -1, 0, -1)};
		// diagonal normal, rounding near ties
		dir_list = {dir_list, make_tri(0, 0, 0, 4096, -4096, 0, 0, 4096, -4096)};
		dir_list = {dir_list, make_tri(7, -3, 11, 1000, 2, -5, -300, 900, 77)};
		foreach (dir_list[i])
			send_triangle(dir_list[i], i != dir_list.size() - 1);

		// hold off until everything has drained
		while (pending != 0)
			@(negedge clk);

		for (int n = 0; n < 500; ) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && n < 500; k++, n++) begin
				mode = $urandom_range(0, 9);
				if (mode == 9) begin
					t = '0;
					t.vertex_a_x = rand_coord(2); t.vertex_a_y = rand_coord(2);
					t.vertex_a_z = rand_coord(2);
					t.vertex_b_x = t.vertex_a_x + rand_coord(1);
					t.vertex_b_y = t.vertex_a_y + rand_coord(1);
					t.vertex_b_z = t.vertex_a_z + rand_coord(1);
					t.vertex_c_x = t.vertex_a_x + rand_coord(1);
					t.vertex_c_y = t.vertex_a_y + rand_coord(1);
					t.vertex_c_z = t.vertex_a_z + rand_coord(1);
				end else begin
					mode = mode < 2 ? 0 : (mode < 4 ? 1 : 2);
					t.vertex_a_x = rand_coord(mode); t.vertex_a_y = rand_coord(mode);
					t.vertex_a_z = rand_coord(mode); t.vertex_b_x = rand_coord(mode);
					t.vertex_b_y = rand_coord(mode); t.vertex_b_z = rand_coord(mode);
					t.vertex_c_x = rand_coord(mode); t.vertex_c_y = rand_coord(mode);
					t.vertex_c_z = rand_coord(mode);
				end
				send_triangle(t, k != burst - 1 && n != 499);
			end
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end

		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* sim.f */
src/tun_pkg.sv
src/triangle_unit_normal_top.sv
tb/tun_checker.sv
tb/tb_triangle_unit_normal_top.sv
